// ----- sv/lph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned KeyInW   = 32;
  localparam int unsigned BucketW  = 9;
  localparam int unsigned SlotOutW = 8;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [KeyInW-1:0] key;
  } req_t;

endpackage
`default_nettype wire

// ----- sv/linear_probe_hash_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressed hash table with division hashing and linear probing.
// ----------------------------------------------------------------------------
// Each request (search, insert or delete of a key) gives exactly one response
// with a status and a bucket index. The home bucket is key modulo the bucket
// count, computed four key bits per cycle; the probe then reads one bucket of
// the bucket RAM per probe step, a read state followed by a check state.
// A two-entry request queue takes new requests while the back end is busy,
// and a finished response waits in an output register. After reset the
// bucket RAM is cleared one bucket per cycle over min(TABLE_DEPTH,511)
// buckets, during which no request is taken; the bucket count may be written
// anytime the table is idle and applies from the next request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [8:0]  cfg_wr_data_i,   // bucket_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // [31:0] key
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,    // [7:0] slot_index
  output logic [2:0]       m_axis_tuser     // [2:0] status
);
  import lph_pkg::*;

  logic [BucketW-1:0] bucket_count_q;
  logic               clearing;
  logic               req_valid, req_ready;
  req_t               req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= 9'd256;
    end else if (cfg_wr_en_i) begin
      bucket_count_q <= cfg_wr_data_i;
    end
  end

  lph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (clearing),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_type_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  lph_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .clearing_o     (clearing),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_status_o   (m_axis_tuser),
    .res_slot_o     (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- sv/lph_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/lph_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_front
// Accepts requests, decodes the request type and queues them for the back end.
// ----------------------------------------------------------------------------
module lph_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          hold_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    in_type_i,
  input  wire logic [31:0]   in_key_i,
  output logic               req_valid_o,
  input  wire logic          req_ready_i,
  output lph_pkg::req_t      req_o
);
  import lph_pkg::*;

  req_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  req_t       dec;

  // The unused request type is handled as a search.
  always_comb begin
    dec.key = in_key_i;
    case (in_type_i)
      OP_INSERT: dec.op = OP_INSERT;
      OP_DELETE: dec.op = OP_DELETE;
      default:   dec.op = OP_SEARCH;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2) && !hold_i;
  assign push        = in_valid_i && in_ready_o;
  assign req_valid_o = (count_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lph_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_back
// Computes the home bucket, walks the probe chain in the bucket RAM, updates
// the table and holds the response in an output register.
// ----------------------------------------------------------------------------
module lph_back #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [8:0]   bucket_count_i,
  output logic              clearing_o,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  input  wire lph_pkg::req_t req_i,
  output logic              res_valid_o,
  input  wire logic         res_ready_i,
  output logic [2:0]        res_status_o,
  output logic [7:0]        res_slot_o
);
  import lph_pkg::*;

  // Buckets beyond what the 9-bit bucket count can reach are never used.
  localparam int unsigned UsedDepth = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
  localparam int unsigned IdxW      = $clog2(UsedDepth);
  localparam int unsigned KwEff     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int unsigned DivSteps  = (KwEff + 3) / 4;
  localparam int unsigned DivW      = DivSteps * 4;
  localparam int unsigned CntW      = $clog2(DivSteps + 1);
  localparam int unsigned WordW     = KEY_WIDTH + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [IdxW-1:0]      j_q, j_d;
  logic [IdxW-1:0]      start_q, start_d;
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [DivW-1:0]      sr_q, sr_d;
  logic [8:0]           rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  status_e              status_q, status_d;
  logic [7:0]           slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [7:0]           out_slot_q, out_slot_d;

  logic [8:0]           d;
  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH+31:0] key_pad;
  logic [DivW+KEY_WIDTH-1:0] div_pad;
  logic [8:0]           rem_step;
  logic [9:0]           trial;
  logic [9:0]           j_inc;
  logic [IdxW-1:0]      j_next;
  logic [IdxW+7:0]      j_pad;
  logic                 ram_we, ram_re;
  logic [WordW-1:0]     ram_wdata, ram_rdata;
  logic                 occ, match, out_free;

  // Effective divisor: zero acts as one, too large acts as the table depth.
  always_comb begin
    if (bucket_count_i == 9'd0) begin
      d = 9'd1;
    end else if (32'(bucket_count_i) > 32'(UsedDepth)) begin
      d = 9'(UsedDepth);
    end else begin
      d = bucket_count_i;
    end
  end

  assign key_pad = {{KEY_WIDTH{1'b0}}, req_i.key};
  assign key_in  = key_pad[KEY_WIDTH-1:0];
  assign div_pad = {{DivW{1'b0}}, key_in};

  // Four restoring remainder steps per cycle.
  always_comb begin
    rem_step = rem_q;
    trial    = 10'd0;
    for (int i = 0; i < 4; i++) begin
      trial = {rem_step, sr_q[DivW-1-i]};
      if (trial >= {1'b0, d}) begin
        trial = trial - {1'b0, d};
      end
      rem_step = trial[8:0];
    end
  end

  assign j_inc  = 10'(j_q) + 10'd1;
  assign j_next = (j_inc == {1'b0, d}) ? '0 : j_inc[IdxW-1:0];
  assign j_pad  = {8'd0, j_q};

  assign occ      = ram_rdata[KEY_WIDTH];
  assign match    = occ && (ram_rdata[KEY_WIDTH-1:0] == key_q);
  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    start_d   = start_q;
    op_d      = op_q;
    key_d     = key_q;
    sr_d      = sr_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    slot_d    = slot_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = '0;
    out_valid_d  = out_valid_q && !res_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        j_d    = j_q + 1'b1;
        if (j_q == IdxW'(UsedDepth - 1)) begin
          j_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_i.op;
          key_d   = key_in;
          sr_d    = div_pad[DivW-1:0];
          rem_d   = 9'd0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_step;
        sr_d  = sr_q << 4;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          j_d     = rem_step[IdxW-1:0];
          start_d = rem_step[IdxW-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!occ || match) begin
          state_d = S_DONE;
          slot_d  = j_pad[7:0];
          case (op_q)
            OP_INSERT: begin
              if (match) begin
                status_d = ST_DUPLICATE;
              end else begin
                status_d  = ST_INSERTED;
                ram_we    = 1'b1;
                ram_wdata = {1'b1, key_q};
              end
            end
            OP_DELETE: begin
              if (match) begin
                status_d  = ST_DELETED;
                ram_we    = 1'b1;
                ram_wdata = {1'b0, key_q};
              end else begin
                status_d = ST_NOT_FOUND;
                slot_d   = 8'd0;
              end
            end
            default: begin
              if (match) begin
                status_d = ST_FOUND;
              end else begin
                status_d = ST_NOT_FOUND;
                slot_d   = 8'd0;
              end
            end
          endcase
        end else if (j_next == start_q) begin
          // Every bucket visited without a stop.
          state_d  = S_DONE;
          slot_d   = 8'd0;
          status_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          j_d     = j_next;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_slot_d   = slot_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    op_q         <= op_d;
    key_q        <= key_d;
    sr_q         <= sr_d;
    rem_q        <= rem_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  // Each word holds the occupied mark above the stored key.
  lph_ram #(
    .WIDTH (WordW),
    .DEPTH (UsedDepth)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (j_q),
    .rdata_o (ram_rdata)
  );

  assign clearing_o   = (state_q == S_CLEAR);
  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_slot_o   = out_slot_q;

endmodule
`default_nettype wire
